// File: rtl/cpu8_pkg.sv
package cpu8_pkg;

  localparam logic [7:0] OpNop    = 8'hEA;
  localparam logic [7:0] OpLdaImm = 8'hA9;
  localparam logic [7:0] OpLdaZp  = 8'hA5;
  localparam logic [7:0] OpLdxImm = 8'hA2;
  localparam logic [7:0] OpLdyImm = 8'hA0;
  localparam logic [7:0] OpStaZp  = 8'h85;
  localparam logic [7:0] OpTax    = 8'hAA;
  localparam logic [7:0] OpTay    = 8'hA8;
  localparam logic [7:0] OpTxa    = 8'h8A;
  localparam logic [7:0] OpTya    = 8'h98;
  localparam logic [7:0] OpInx    = 8'hE8;
  localparam logic [7:0] OpIny    = 8'hC8;
  localparam logic [7:0] OpDex    = 8'hCA;
  localparam logic [7:0] OpDey    = 8'h88;
  localparam logic [7:0] OpClc    = 8'h18;
  localparam logic [7:0] OpSec    = 8'h38;
  localparam logic [7:0] OpAdcImm = 8'h69;
  localparam logic [7:0] OpJmpAbs = 8'h4C;
  localparam logic [7:0] OpBeq    = 8'hF0;
  localparam logic [7:0] OpBne    = 8'hD0;

  localparam int unsigned FlCarry    = 0;
  localparam int unsigned FlZero     = 1;
  localparam int unsigned FlOverflow = 6;
  localparam int unsigned FlSign     = 7;

  localparam logic [7:0] FlagsReset = 8'h20;

  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  flags;
    logic [31:0] ticks;
  } arch_t;

  typedef struct packed {
    logic       vector_load;
    logic [7:0] opcode;
    logic [7:0] operand_low;
    logic [7:0] operand_high;
    logic [7:0] load_data;
  } instr_t;

  typedef struct packed {
    logic       store_enable;
    logic [7:0] store_address;
    logic [7:0] store_data;
    logic [1:0] instr_cycles;
  } side_t;

endpackage

// File: rtl/cpu8_exec.sv
module cpu8_exec
  import cpu8_pkg::*;
(
  input  arch_t  arch_i,
  input  instr_t instr_i,
  output arch_t  arch_o,
  output side_t  side_o
);

  logic [15:0] pc1;
  logic [15:0] pc2;
  logic [15:0] abs_addr;
  logic [15:0] br_target;
  logic [8:0]  sum;
  logic [7:0]  adc_res;
  logic        adc_v;
  logic        take;
  logic [1:0]  cyc;
  arch_t       nx;

  function automatic logic [7:0] with_nz(input logic [7:0] f, input logic [7:0] v);
    logic [7:0] r;
    r = f;
    r[FlZero] = (v == 8'h00);
    r[FlSign] = v[7];
    return r;
  endfunction

  assign pc1       = arch_i.pc + 16'd1;
  assign pc2       = arch_i.pc + 16'd2;
  assign abs_addr  = {instr_i.operand_high, instr_i.operand_low};
  assign br_target = pc2 + {{8{instr_i.operand_low[7]}}, instr_i.operand_low};

  assign sum     = {1'b0, arch_i.acc} + {1'b0, instr_i.operand_low}
                 + {8'd0, arch_i.flags[FlCarry]};
  assign adc_res = sum[7:0];
  assign adc_v   = ~(arch_i.acc[7] ^ instr_i.operand_low[7]) & (arch_i.acc[7] ^ adc_res[7]);

  always_comb begin
    nx = arch_i;
    cyc = 2'd2;
    take = 1'b0;
    side_o.store_enable  = 1'b0;
    side_o.store_address = 8'h00;
    side_o.store_data    = 8'h00;
    if (instr_i.vector_load) begin
      nx.pc = abs_addr;
      cyc = 2'd0;
    end else begin
      unique case (instr_i.opcode) inside
        OpLdaImm: begin
          nx.acc = instr_i.operand_low;
          nx.flags = with_nz(arch_i.flags, instr_i.operand_low);
          nx.pc = pc2;
        end
        OpLdaZp: begin
          nx.acc = instr_i.load_data;
          nx.flags = with_nz(arch_i.flags, instr_i.load_data);
          nx.pc = pc2;
          cyc = 2'd3;
        end
        OpLdxImm: begin
          nx.x = instr_i.operand_low;
          nx.flags = with_nz(arch_i.flags, instr_i.operand_low);
          nx.pc = pc2;
        end
        OpLdyImm: begin
          nx.y = instr_i.operand_low;
          nx.flags = with_nz(arch_i.flags, instr_i.operand_low);
          nx.pc = pc2;
        end
        OpStaZp: begin
          side_o.store_enable  = 1'b1;
          side_o.store_address = instr_i.operand_low;
          side_o.store_data    = arch_i.acc;
          nx.pc = pc2;
          cyc = 2'd3;
        end
        OpTax: begin
          nx.x = arch_i.acc;
          nx.flags = with_nz(arch_i.flags, arch_i.acc);
          nx.pc = pc1;
        end
        OpTay: begin
          nx.y = arch_i.acc;
          nx.flags = with_nz(arch_i.flags, arch_i.acc);
          nx.pc = pc1;
        end
        OpTxa: begin
          nx.acc = arch_i.x;
          nx.flags = with_nz(arch_i.flags, arch_i.x);
          nx.pc = pc1;
        end
        OpTya: begin
          nx.acc = arch_i.y;
          nx.flags = with_nz(arch_i.flags, arch_i.y);
          nx.pc = pc1;
        end
        OpInx: begin
          nx.x = arch_i.x + 8'd1;
          nx.flags = with_nz(arch_i.flags, nx.x);
          nx.pc = pc1;
        end
        OpIny: begin
          nx.y = arch_i.y + 8'd1;
          nx.flags = with_nz(arch_i.flags, nx.y);
          nx.pc = pc1;
        end
        OpDex: begin
          nx.x = arch_i.x - 8'd1;
          nx.flags = with_nz(arch_i.flags, nx.x);
          nx.pc = pc1;
        end
        OpDey: begin
          nx.y = arch_i.y - 8'd1;
          nx.flags = with_nz(arch_i.flags, nx.y);
          nx.pc = pc1;
        end
        OpClc: begin
          nx.flags[FlCarry] = 1'b0;
          nx.pc = pc1;
        end
        OpSec: begin
          nx.flags[FlCarry] = 1'b1;
          nx.pc = pc1;
        end
        OpAdcImm: begin
          nx.acc = adc_res;
          nx.flags = with_nz(arch_i.flags, adc_res);
          nx.flags[FlCarry] = sum[8];
          nx.flags[FlOverflow] = adc_v;
          nx.pc = pc2;
        end
        OpJmpAbs: begin
          nx.pc = abs_addr;
          cyc = 2'd3;
        end
        OpBeq, OpBne: begin
          // BEQ takes on Z set, BNE on Z clear
          take = arch_i.flags[FlZero] ^ (instr_i.opcode == OpBne);
          nx.pc = take ? br_target : pc2;
          cyc = take ? 2'd3 : 2'd2;
        end
        default: begin
          nx.pc = pc1;
        end
      endcase
    end
    nx.ticks = arch_i.ticks + {30'd0, cyc};
    side_o.instr_cycles = cyc;
  end

  assign arch_o = nx;

endmodule

// File: rtl/cpu8_subset_instruction_execute_core.sv
// Two register stages: the input register, then execute into the
// result/architectural registers, which load once the result slot is free.
// Throughput: one instruction per cycle while the result is not stalled; an
// 8-bit add, the 16-bit PC adds and the 32-bit tick add stand between the two
// register stages.
// Reset: PC, A, X, Y and tick total clear, flags go to 0x20, both stages empty.
module cpu8_subset_instruction_execute_core
  import cpu8_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        vector_load_i,
  input  logic [7:0]  opcode_i,
  input  logic [7:0]  operand_low_i,
  input  logic [7:0]  operand_high_i,
  input  logic [7:0]  load_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] next_pc_o,
  output logic [7:0]  acc_value_o,
  output logic [7:0]  x_value_o,
  output logic [7:0]  y_value_o,
  output logic [7:0]  flags_value_o,
  output logic        store_enable_o,
  output logic [7:0]  store_address_o,
  output logic [7:0]  store_data_o,
  output logic [1:0]  instr_cycles_o,
  output logic [31:0] total_ticks_o
);

  logic   in_vld_q;
  instr_t instr_q;
  logic   out_vld_q;
  arch_t  arch_q;
  arch_t  arch_d;
  side_t  side_q;
  side_t  side_d;
  logic   out_ready;
  logic   advance;
  logic   in_load;

  // Architectural registers double as the result register: they only move
  // when the result slot is free, so a stalled result beat stays intact.
  assign out_ready  = ~out_vld_q | ~out_stall_i;
  assign advance    = in_vld_q & out_ready;
  assign in_stall_o = in_vld_q & ~out_ready;
  assign in_load    = in_valid_i & ~in_stall_o;

  cpu8_exec u_exec (
    .arch_i  (arch_q),
    .instr_i (instr_q),
    .arch_o  (arch_d),
    .side_o  (side_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (~in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      instr_q.vector_load  <= vector_load_i;
      instr_q.opcode       <= opcode_i;
      instr_q.operand_low  <= operand_low_i;
      instr_q.operand_high <= operand_high_i;
      instr_q.load_data    <= load_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      arch_q.pc    <= 16'h0000;
      arch_q.acc   <= 8'h00;
      arch_q.x     <= 8'h00;
      arch_q.y     <= 8'h00;
      arch_q.flags <= FlagsReset;
      arch_q.ticks <= 32'd0;
    end else begin
      if (out_ready) begin
        out_vld_q <= in_vld_q;
      end
      if (advance) begin
        arch_q <= arch_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      side_q <= side_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign next_pc_o       = arch_q.pc;
  assign acc_value_o     = arch_q.acc;
  assign x_value_o       = arch_q.x;
  assign y_value_o       = arch_q.y;
  assign flags_value_o   = arch_q.flags;
  assign total_ticks_o   = arch_q.ticks;
  assign store_enable_o  = side_q.store_enable;
  assign store_address_o = side_q.store_address;
  assign store_data_o    = side_q.store_data;
  assign instr_cycles_o  = side_q.instr_cycles;

endmodule

// File: test/cpu8_subset_instruction_execute_core_test.sv
module cpu8_subset_instruction_execute_core_test
  import cpu8_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned RandItems  = 1350;
  localparam int unsigned HoldAt     = 300;
  localparam int unsigned HoldLen    = 80;
  localparam int unsigned DrainAt    = 800;

  typedef struct {
    instr_t ins;
    bit     drain;
  } pending_t;

  typedef struct {
    logic [15:0] pc;
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  flags;
    logic        st_en;
    logic [7:0]  st_addr;
    logic [7:0]  st_data;
    logic [1:0]  cyc;
    logic [31:0] ticks;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [15:0] next_pc_o;
  logic [7:0]  acc_value_o;
  logic [7:0]  x_value_o;
  logic [7:0]  y_value_o;
  logic [7:0]  flags_value_o;
  logic        store_enable_o;
  logic [7:0]  store_address_o;
  logic [7:0]  store_data_o;
  logic [1:0]  instr_cycles_o;
  logic [31:0] total_ticks_o;

  instr_t cur_beat = '0;

  pending_t pending[$];
  outcome_t expected_state[$];
  int unsigned n_items;
  int unsigned acc_cnt = 0;
  int unsigned seen_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_fired = 1'b0;

  // architectural state of the predictor
  logic [15:0] cpu_pc = '0;
  logic [7:0]  cpu_a = '0;
  logic [7:0]  cpu_x = '0;
  logic [7:0]  cpu_y = '0;
  logic [7:0]  cpu_p = FlagsReset;
  logic [31:0] cpu_ticks = '0;

  logic [7:0] known_ops[19] = '{OpLdaImm, OpLdaZp, OpLdxImm, OpLdyImm, OpStaZp, OpTax,
                                OpTay, OpTxa, OpTya, OpInx, OpIny, OpDex, OpDey, OpClc,
                                OpSec, OpAdcImm, OpJmpAbs, OpBeq, OpBne};

  cpu8_subset_instruction_execute_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .vector_load_i  (cur_beat.vector_load),
    .opcode_i       (cur_beat.opcode),
    .operand_low_i  (cur_beat.operand_low),
    .operand_high_i (cur_beat.operand_high),
    .load_data_i    (cur_beat.load_data),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .next_pc_o      (next_pc_o),
    .acc_value_o    (acc_value_o),
    .x_value_o      (x_value_o),
    .y_value_o      (y_value_o),
    .flags_value_o  (flags_value_o),
    .store_enable_o (store_enable_o),
    .store_address_o(store_address_o),
    .store_data_o   (store_data_o),
    .instr_cycles_o (instr_cycles_o),
    .total_ticks_o  (total_ticks_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [7:0] with_nz(logic [7:0] p, logic [7:0] v);
    logic [7:0] f;
    f = p;
    f[FlZero] = (v == 8'h00);
    f[FlSign] = v[7];
    return f;
  endfunction

  task automatic execute_instr(instr_t b);
    outcome_t   o;
    logic [15:0] pc1;
    logic [15:0] pc2;
    logic [8:0]  sum;
    logic        taken;
    pc1 = cpu_pc + 16'd1;
    pc2 = cpu_pc + 16'd2;
    o.st_en = 1'b0;
    o.st_addr = '0;
    o.st_data = '0;
    o.cyc = 2'd2;
    if (b.vector_load) begin
      cpu_pc = {b.operand_high, b.operand_low};
      o.cyc = 2'd0;
    end else begin
      case (b.opcode) inside
        OpLdaImm: begin cpu_a = b.operand_low; cpu_p = with_nz(cpu_p, cpu_a); cpu_pc = pc2; end
        OpLdaZp: begin
          cpu_a = b.load_data; cpu_p = with_nz(cpu_p, cpu_a); cpu_pc = pc2; o.cyc = 2'd3;
        end
        OpLdxImm: begin cpu_x = b.operand_low; cpu_p = with_nz(cpu_p, cpu_x); cpu_pc = pc2; end
        OpLdyImm: begin cpu_y = b.operand_low; cpu_p = with_nz(cpu_p, cpu_y); cpu_pc = pc2; end
        OpStaZp: begin
          o.st_en = 1'b1; o.st_addr = b.operand_low; o.st_data = cpu_a;
          cpu_pc = pc2; o.cyc = 2'd3;
        end
        OpTax: begin cpu_x = cpu_a; cpu_p = with_nz(cpu_p, cpu_x); cpu_pc = pc1; end
        OpTay: begin cpu_y = cpu_a; cpu_p = with_nz(cpu_p, cpu_y); cpu_pc = pc1; end
        OpTxa: begin cpu_a = cpu_x; cpu_p = with_nz(cpu_p, cpu_a); cpu_pc = pc1; end
        OpTya: begin cpu_a = cpu_y; cpu_p = with_nz(cpu_p, cpu_a); cpu_pc = pc1; end
        OpInx: begin cpu_x = cpu_x + 8'd1; cpu_p = with_nz(cpu_p, cpu_x); cpu_pc = pc1; end
        OpIny: begin cpu_y = cpu_y + 8'd1; cpu_p = with_nz(cpu_p, cpu_y); cpu_pc = pc1; end
        OpDex: begin cpu_x = cpu_x - 8'd1; cpu_p = with_nz(cpu_p, cpu_x); cpu_pc = pc1; end
        OpDey: begin cpu_y = cpu_y - 8'd1; cpu_p = with_nz(cpu_p, cpu_y); cpu_pc = pc1; end
        OpClc: begin cpu_p[FlCarry] = 1'b0; cpu_pc = pc1; end
        OpSec: begin cpu_p[FlCarry] = 1'b1; cpu_pc = pc1; end
        OpAdcImm: begin
          sum = {1'b0, cpu_a} + {1'b0, b.operand_low} + {8'd0, cpu_p[FlCarry]};
          // signed overflow: operands agree in sign, result does not
          cpu_p[FlOverflow] = ~(cpu_a[7] ^ b.operand_low[7]) & (cpu_a[7] ^ sum[7]);
          cpu_p[FlCarry] = sum[8];
          cpu_a = sum[7:0];
          cpu_p = with_nz(cpu_p, cpu_a);
          cpu_pc = pc2;
        end
        OpJmpAbs: begin cpu_pc = {b.operand_high, b.operand_low}; o.cyc = 2'd3; end
        OpBeq, OpBne: begin
          taken = (b.opcode == OpBeq) ? cpu_p[FlZero] : !cpu_p[FlZero];
          cpu_pc = pc2;
          if (taken) begin
            cpu_pc = pc2 + {{8{b.operand_low[7]}}, b.operand_low};
            o.cyc = 2'd3;
          end
        end
        default: cpu_pc = pc1;
      endcase
    end
    cpu_ticks = cpu_ticks + 32'(o.cyc);
    o.pc = cpu_pc;
    o.acc = cpu_a;
    o.x = cpu_x;
    o.y = cpu_y;
    o.flags = cpu_p;
    o.ticks = cpu_ticks;
    expected_state.push_back(o);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // mostly short gaps, a few long; every fourth window of the cycle count (cycle_cnt >> 9) has none
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (((cycle_cnt >> 9) % 4) == 0) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic add_op(logic [7:0] op, logic [7:0] lo, logic [7:0] hi = 8'h00,
                        logic [7:0] mem = 8'h00, bit drain = 1'b0);
    pending_t p;
    p.ins = '{vector_load: 1'b0, opcode: op, operand_low: lo, operand_high: hi,
              load_data: mem};
    p.drain = drain;
    pending.push_back(p);
  endtask

  task automatic add_vector(logic [7:0] lo, logic [7:0] hi, logic [7:0] op, logic [7:0] mem);
    pending_t p;
    p.ins = '{vector_load: 1'b1, opcode: op, operand_low: lo, operand_high: hi,
              load_data: mem};
    p.drain = 1'b0;
    pending.push_back(p);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic     take;
    pending_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left <= 0;
    end else begin
      take = in_valid_i && !in_stall_o;
      if (take) begin
        execute_instr(cur_beat);
        acc_cnt <= acc_cnt + 1;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left != 0 && hold_left == 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending.size() != 0 &&
                     !(pending[0].drain && (take || seen_cnt != acc_cnt))) begin
          nxt = pending.pop_front();
          cur_beat <= nxt.ins;
          in_valid_i <= 1'b1;
          gap_left <= (hold_left != 0) ? 0 : pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off while the sender keeps pushing
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_fired <= 1'b0;
    end else if (!hold_fired && acc_cnt >= HoldAt) begin
      hold_left <= HoldLen;
      hold_fired <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin : watch
    outcome_t    want;
    int unsigned g;
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
      stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen_cnt <= seen_cnt + 1;
        if (expected_state.size() == 0) begin
          report_mismatch("result beat with nothing pending", 32'(next_pc_o), 0);
        end else begin
          want = expected_state.pop_front();
          if (next_pc_o !== want.pc)
            report_mismatch("next_pc", 32'(next_pc_o), 32'(want.pc));
          if (acc_value_o !== want.acc)
            report_mismatch("acc_value", 32'(acc_value_o), 32'(want.acc));
          if (x_value_o !== want.x)
            report_mismatch("x_value", 32'(x_value_o), 32'(want.x));
          if (y_value_o !== want.y)
            report_mismatch("y_value", 32'(y_value_o), 32'(want.y));
          if (flags_value_o !== want.flags)
            report_mismatch("flags_value", 32'(flags_value_o), 32'(want.flags));
          if (store_enable_o !== want.st_en)
            report_mismatch("store_enable", 32'(store_enable_o), 32'(want.st_en));
          if (store_address_o !== want.st_addr)
            report_mismatch("store_address", 32'(store_address_o), 32'(want.st_addr));
          if (store_data_o !== want.st_data)
            report_mismatch("store_data", 32'(store_data_o), 32'(want.st_data));
          if (instr_cycles_o !== want.cyc)
            report_mismatch("instr_cycles", 32'(instr_cycles_o), 32'(want.cyc));
          if (total_ticks_o !== want.ticks)
            report_mismatch("total_ticks", total_ticks_o, want.ticks);
        end
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        g = ($urandom_range(2) == 0) ? pick_gap() : 0;
        out_stall_i <= (g != 0);
        if (g != 0) stall_left <= g - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL cpu8_subset_instruction_execute_core");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned r;
    logic [7:0]  op;
    // directed: vector, PC wrap, flags, branches both ways, every opcode
    add_vector(8'hFC, 8'hFF, OpLdaImm, 8'h5A);
    add_op(OpNop, 8'h00);
    add_op(OpLdaImm, 8'h00);
    add_op(OpBeq, 8'h7F);                    // taken, target wraps past 0xFFFF
    add_op(OpLdaImm, 8'h80);
    add_op(OpBne, 8'h80);                    // taken, most negative offset
    add_op(OpBeq, 8'h10);                    // not taken
    add_op(OpLdxImm, 8'hFF);
    add_op(OpInx, 8'h00);                    // X wraps to zero
    add_op(OpLdyImm, 8'h00);
    add_op(OpDey, 8'h00);                    // Y wraps to 0xFF
    add_op(OpLdaZp, 8'h10, 8'h00, 8'hFF);
    add_op(OpStaZp, 8'hFF, 8'hFF, 8'hFF);
    add_op(OpTax, 8'h00);
    add_op(OpIny, 8'h00);
    add_op(OpTay, 8'h00);
    add_op(OpDex, 8'h00);
    add_op(OpTxa, 8'h00);
    add_op(OpTya, 8'h00);
    add_op(OpClc, 8'h00);
    add_op(OpLdaImm, 8'h7F);
    add_op(OpAdcImm, 8'h01);                 // signed overflow
    add_op(OpSec, 8'h00);
    add_op(OpAdcImm, 8'hFF);                 // carry in and out
    add_op(OpClc, 8'h00);
    add_op(OpLdaImm, 8'h80);
    add_op(OpAdcImm, 8'h80);                 // zero, carry and overflow at once
    add_op(OpJmpAbs, 8'hFF, 8'hFF);
    add_op(8'hFF, 8'hAA, 8'h55, 8'hC3);      // unknown opcode, PC wraps to zero
    add_op(8'h00, 8'h00, 8'h00, 8'h00);

    for (int unsigned i = 0; i < RandItems; i++) begin
      r = $urandom_range(99);
      if (r < 5) begin
        add_vector(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
      end else begin
        op = (r < 30) ? 8'($urandom_range(255)) : known_ops[$urandom_range(18)];
        add_op(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)), i == DrainAt);
      end
    end
    n_items = pending.size();

    while (acc_cnt != n_items || seen_cnt < acc_cnt) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (expected_state.size() != 0)
      report_mismatch("results never delivered", expected_state.size(), 0);
    if (err_cnt == 0) begin
      $display("PASS cpu8_subset_instruction_execute_core");
    end else begin
      $display("FAIL cpu8_subset_instruction_execute_core");
    end
    $finish;
  end

endmodule
